@@ rtl/pwl_pkg.sv @@
package pwl_pkg;

  localparam int TIME_W = 32;
  localparam int FLOW_W = 32;
  localparam int MAG_W  = FLOW_W + 1;
  localparam int PROD_W = TIME_W + MAG_W;

  typedef enum logic [1:0] {
    MODE_QUERY  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0] tick;
    logic [FLOW_W-1:0] flow;
  } entry_t;

endpackage

@@ rtl/pwl_frac.sv @@
module pwl_frac import pwl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] off,
  input  logic [TIME_W-1:0] span,
  input  logic [MAG_W-1:0]  mag,
  output logic              done,
  output logic [MAG_W-1:0]  term
);

  localparam int CNT_W = $clog2(PROD_W);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV} phase_t;

  phase_t            phase;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] rem;
  logic [MAG_W-1:0]  mag_r;
  logic [TIME_W-1:0] span_r;
  logic [MAG_W-1:0]  op_a;
  logic [MAG_W-1:0]  op_b;
  logic              op_c;
  logic [MAG_W:0]    sum;

  // shared adder: add multiplicand in multiply, subtract divisor in divide
  always_comb begin
    if (phase == F_DIV) begin
      op_a = {rem, prod[PROD_W-1]};
      op_b = ~{1'b0, span_r};
      op_c = 1'b1;
    end else begin
      op_a = prod[PROD_W-1:TIME_W];
      op_b = prod[0] ? mag_r : '0;
      op_c = 1'b0;
    end
    sum = {1'b0, op_a} + {1'b0, op_b} + {{MAG_W{1'b0}}, op_c};
  end

  assign term = prod[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        F_IDLE: begin
          if (start) begin
            prod   <= {{MAG_W{1'b0}}, off};
            rem    <= '0;
            mag_r  <= mag;
            span_r <= span;
            cnt    <= CNT_W'(TIME_W - 1);
            phase  <= F_MUL;
          end
        end
        F_MUL: begin
          prod <= {sum, prod[TIME_W-1:1]};
          if (cnt == '0) begin
            cnt   <= CNT_W'(PROD_W - 1);
            phase <= F_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        F_DIV: begin
          if (sum[MAG_W]) begin
            rem <= sum[TIME_W-1:0];
          end else begin
            rem <= op_a[TIME_W-1:0];
          end
          prod <= {prod[PROD_W-2:0], sum[MAG_W]};
          if (cnt == '0) begin
            done  <= 1'b1;
            phase <= F_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: phase <= F_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/piecewise_linear_table_interp_top.sv @@
// Breakpoint table with clamped linear interpolation. Drive start with mode,
// time_value and flow_value; the item transfers when start is high and busy is
// low. Each item gives exactly one result, shown on flow_out and status for a
// single cycle while done is high; the receiver cannot stall it, so sample it
// then. Append, clear and unused modes, and a query on an empty table, answer
// in the cycle after the transfer and a new item may follow at once. A query
// walks the table one entry per cycle through the single read port of the
// table memory. A query that ends in an interval of zero length needs no
// fraction; one that needs it passes through a launch step, 32 multiply
// steps and 65 divide steps of one shared 34-bit adder, and a step to apply
// the sign. A query outside every interval answers when the scan reaches the
// last entry.
module piecewise_linear_table_interp_top import pwl_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [1:0]               mode,
  input  logic [TIME_W-1:0]        time_value,
  input  logic signed [FLOW_W-1:0] flow_value,
  output logic                     busy,
  output logic                     done,
  output logic signed [FLOW_W-1:0] flow_out,
  output logic [1:0]               status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ0, S_SCAN, S_PREP, S_FRAC} state_t;

  state_t            state;
  entry_t            mem [DEPTH];
  entry_t            rd_data;
  entry_t            prev_e;
  entry_t            first_e;
  entry_t            lo_e;
  entry_t            hi_e;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     pos;
  logic [CW-1:0]     count;
  logic [TIME_W-1:0] qtime;
  logic [TIME_W-1:0] off_r;
  logic [TIME_W-1:0] span_r;
  logic [MAG_W-1:0]  mag_r;
  logic              neg;
  logic              frac_start;
  logic              frac_done;
  logic [MAG_W-1:0]  term;
  logic              accept;
  logic              hit;
  logic              last;
  logic [TIME_W-1:0] span_w;
  logic [TIME_W-1:0] off_w;
  logic [MAG_W-1:0]  step;
  logic [MAG_W-1:0]  mag_w;
  logic [MAG_W-1:0]  base;
  logic [MAG_W-1:0]  res;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    hit    = (qtime >= prev_e.tick) && (qtime <= rd_data.tick);
    last   = (CW'(pos) + CW'(1)) == count;
    span_w = hi_e.tick - lo_e.tick;
    off_w  = qtime - lo_e.tick;
    step   = {hi_e.flow[FLOW_W-1], hi_e.flow} - {lo_e.flow[FLOW_W-1], lo_e.flow};
    mag_w  = step[MAG_W-1] ? (~step + 1'b1) : step;
    base   = {lo_e.flow[FLOW_W-1], lo_e.flow};
    res    = neg ? (base - term) : (base + term);
  end

  always_ff @(posedge clk) begin
    if (accept && mode == MODE_APPEND && count < CW'(DEPTH)) begin
      mem[count[AW-1:0]] <= {time_value, flow_value};
    end
    rd_data <= mem[addr];
  end

  pwl_frac u_frac (
    .clk   (clk),
    .rst   (rst),
    .start (frac_start),
    .off   (off_r),
    .span  (span_r),
    .mag   (mag_r),
    .done  (frac_done),
    .term  (term)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      count      <= '0;
      frac_start <= 1'b0;
    end else begin
      done       <= 1'b0;
      frac_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            flow_out <= '0;
            status   <= ST_OK;
            case (mode)
              MODE_QUERY: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  done   <= 1'b1;
                end else begin
                  qtime <= time_value;
                  addr  <= '0;
                  state <= S_READ0;
                end
              end
              MODE_APPEND: begin
                if (count < CW'(DEPTH)) begin
                  count <= count + 1'b1;
                end else begin
                  status <= ST_FULL;
                end
                done <= 1'b1;
              end
              MODE_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_READ0: begin
          addr  <= addr + 1'b1;
          pos   <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          addr   <= addr + 1'b1;
          pos    <= pos + 1'b1;
          prev_e <= rd_data;
          if (pos == '0) begin
            first_e <= rd_data;
          end
          if (pos != '0 && hit) begin
            lo_e  <= prev_e;
            hi_e  <= rd_data;
            state <= S_PREP;
          end else if (last) begin
            // hold the first or the last flow outside the table
            if (pos != '0 && qtime < first_e.tick) begin
              flow_out <= first_e.flow;
            end else begin
              flow_out <= rd_data.flow;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_PREP: begin
          if (span_w == '0) begin
            flow_out <= lo_e.flow;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            off_r      <= off_w;
            span_r     <= span_w;
            mag_r      <= mag_w;
            neg        <= step[MAG_W-1];
            frac_start <= 1'b1;
            state      <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (frac_done) begin
            flow_out <= res[FLOW_W-1:0];
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (flow_out == '0))
    else $error("error result carries nonzero flow");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted item neither answered nor in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0))
    else $error("scan on empty table");

  a_frac_launch: assert property (@(posedge clk) disable iff (rst)
    frac_start |=> (state == S_FRAC && !frac_done))
    else $error("fraction unit launched outside its wait state");
`endif

endmodule
